// ----- hdl/swbx_pkg.sv -----
`timescale 1ns / 1ps
package swbx_pkg;

    localparam int DATA_W            = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int DW                = 38;
    localparam int NRM_W             = 2;
    localparam int LANES             = 4;
    localparam int AXES              = 2;
    localparam int QDEPTH            = 4;

    localparam int LN_LX = 0;
    localparam int LN_HX = 1;
    localparam int LN_LY = 2;
    localparam int LN_HY = 3;
    localparam int AX_X  = 0;
    localparam int AX_Y  = 1;

    localparam logic signed [NRM_W-1:0] NRM_ZERO = 2'sb00;
    localparam logic signed [NRM_W-1:0] NRM_POS  = 2'sb01;
    localparam logic signed [NRM_W-1:0] NRM_NEG  = 2'sb11;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic [AXES-1:0]  zero;
        logic [AXES-1:0]  pass;
    } t_side;

    typedef struct packed {
        logic [LANES-1:0][DW-1:0] mag;
        logic [AXES-1:0][DW-1:0]  den;
        t_side                    side;
    } t_cls;

endpackage

// ----- hdl/swbx_intf.sv -----
`timescale 1ns / 1ps
interface swbx_box_if import swbx_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] mover_min_x;
    logic signed [DATA_W-1:0] mover_min_y;
    logic signed [DATA_W-1:0] mover_max_x;
    logic signed [DATA_W-1:0] mover_max_y;
    logic signed [DATA_W-1:0] mover_end_x;
    logic signed [DATA_W-1:0] mover_end_y;
    logic signed [DATA_W-1:0] target_min_x;
    logic signed [DATA_W-1:0] target_min_y;
    logic signed [DATA_W-1:0] target_max_x;
    logic signed [DATA_W-1:0] target_max_y;
    logic signed [DATA_W-1:0] target_end_x;
    logic signed [DATA_W-1:0] target_end_y;

    modport source (
        output valid, mover_min_x, mover_min_y, mover_max_x, mover_max_y,
               mover_end_x, mover_end_y, target_min_x, target_min_y,
               target_max_x, target_max_y, target_end_x, target_end_y,
        input  ready
    );
    modport sink (
        input  valid, mover_min_x, mover_min_y, mover_max_x, mover_max_y,
               mover_end_x, mover_end_y, target_min_x, target_min_y,
               target_max_x, target_max_y, target_end_x, target_end_y,
        output ready
    );
endinterface

interface swbx_toi_if import swbx_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [FRACTION_BITS:0]  impact_time;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;

    modport source (output valid, hit, impact_time, normal_x, normal_y, input ready);
    modport sink   (input  valid, hit, impact_time, normal_x, normal_y, output ready);
endinterface

// ----- hdl/swbx_front.sv -----
`timescale 1ns / 1ps
module swbx_front import swbx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swbx_box_if.sink    i_box,
    output t_cls        o_cls,
    output logic        o_valid,
    input  logic        i_ready
);

    logic                 r_v;
    logic signed [DW-1:0] r_pos [AXES];
    logic signed [DW-1:0] r_vel [AXES];
    logic signed [DW-1:0] r_lo  [AXES];
    logic signed [DW-1:0] r_hi  [AXES];

    logic signed [DW-1:0] amn [AXES];
    logic signed [DW-1:0] amx [AXES];
    logic signed [DW-1:0] ae  [AXES];
    logic signed [DW-1:0] bmn [AXES];
    logic signed [DW-1:0] bmx [AXES];
    logic signed [DW-1:0] be  [AXES];
    logic signed [DW-1:0] pa  [AXES];
    logic signed [DW-1:0] pb  [AXES];
    logic signed [DW-1:0] wd  [AXES];
    logic signed [DW-1:0] num [LANES];
    logic                 acc;

    assign i_box.ready = !r_v || i_ready;
    assign acc         = i_box.valid && i_box.ready;
    assign o_valid     = r_v;

    always_comb begin
        amn[AX_X] = DW'(i_box.mover_min_x);
        amn[AX_Y] = DW'(i_box.mover_min_y);
        amx[AX_X] = DW'(i_box.mover_max_x);
        amx[AX_Y] = DW'(i_box.mover_max_y);
        ae[AX_X]  = DW'(i_box.mover_end_x);
        ae[AX_Y]  = DW'(i_box.mover_end_y);
        bmn[AX_X] = DW'(i_box.target_min_x);
        bmn[AX_Y] = DW'(i_box.target_min_y);
        bmx[AX_X] = DW'(i_box.target_max_x);
        bmx[AX_Y] = DW'(i_box.target_max_y);
        be[AX_X]  = DW'(i_box.target_end_x);
        be[AX_Y]  = DW'(i_box.target_end_y);
        for (int a = 0; a < AXES; a++) begin
            pa[a] = amn[a] + amx[a];
            pb[a] = bmn[a] + bmx[a];
            wd[a] = amx[a] - amn[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_box.ready) begin
            r_v <= i_box.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int a = 0; a < AXES; a++) begin
                r_pos[a] <= pa[a];
                r_vel[a] <= ((ae[a] + ae[a]) - pa[a]) - ((be[a] + be[a]) - pb[a]);
                r_lo[a]  <= (bmn[a] + bmn[a]) - wd[a];
                r_hi[a]  <= (bmx[a] + bmx[a]) + wd[a];
            end
        end
    end

    always_comb begin
        num[LN_LX] = r_lo[AX_X] - r_pos[AX_X];
        num[LN_HX] = r_hi[AX_X] - r_pos[AX_X];
        num[LN_LY] = r_lo[AX_Y] - r_pos[AX_Y];
        num[LN_HY] = r_hi[AX_Y] - r_pos[AX_Y];
        for (int g = 0; g < LANES; g++) begin
            o_cls.mag[g]      = num[g][DW-1] ? DW'(-num[g]) : DW'(num[g]);
            o_cls.side.neg[g] = num[g][DW-1] ^ r_vel[g >> 1][DW-1];
        end
        for (int a = 0; a < AXES; a++) begin
            o_cls.den[a]       = r_vel[a][DW-1] ? DW'(-r_vel[a]) : DW'(r_vel[a]);
            o_cls.side.zero[a] = (r_vel[a] == '0);
            o_cls.side.pass[a] = (r_pos[a] >= r_lo[a]) && (r_pos[a] <= r_hi[a]);
        end
    end

endmodule

// ----- hdl/swbx_fifo.sv -----
`timescale 1ns / 1ps
module swbx_fifo import swbx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cls i_cls,
    input  logic i_valid,
    output logic o_ready,
    output t_cls o_cls,
    output logic o_valid,
    input  logic i_pop
);

    localparam int PW = $clog2(QDEPTH);

    t_cls          r_mem [QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_cls   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (!push && pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cls;
        end
    end

endmodule

// ----- hdl/swbx_div.sv -----
`timescale 1ns / 1ps
module swbx_div import swbx_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [DW-1:0]            i_mag,
    input  logic [DW-1:0]            i_den,
    output logic [FRACTION_BITS+1:0] o_q,
    output logic                     o_rem_nz,
    output logic                     o_sat
);

    localparam int NQ = FRACTION_BITS + 2;
    localparam int RW = DW + 2;

    logic [RW-1:0] r_rem [0:NQ];
    logic [RW-1:0] r_dv  [0:NQ];
    logic [NQ-1:0] r_q   [0:NQ];
    logic          r_sat [0:NQ];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {2'b00, i_mag};
            r_dv[0]  <= {i_den, 2'b00};
            r_q[0]   <= '0;
            r_sat[0] <= ({2'b00, i_mag} >= {i_den, 2'b00});
        end
    end

    for (genvar k = 1; k <= NQ; k++) begin : g_step
        logic [RW:0] sh;
        logic        take;
        assign sh   = {r_rem[k-1], 1'b0};
        assign take = (sh >= {1'b0, r_dv[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? RW'(sh - {1'b0, r_dv[k-1]}) : sh[RW-1:0];
                r_dv[k]  <= r_dv[k-1];
                r_q[k]   <= {r_q[k-1][NQ-2:0], take};
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_q      = r_q[NQ];
    assign o_rem_nz = |r_rem[NQ];
    assign o_sat    = r_sat[NQ];

endmodule

// ----- hdl/swbx_back.sv -----
`timescale 1ns / 1ps
module swbx_back import swbx_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cls        i_cls,
    input  logic        i_valid,
    output logic        o_pop,
    swbx_toi_if.source  o_toi
);

    localparam int NQ = FRACTION_BITS + 2;
    localparam int TW = FRACTION_BITS + 3;
    localparam logic [TW-1:0]        SAT_U = TW'(1) << (FRACTION_BITS + 1);
    localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRACTION_BITS;

    typedef struct packed {
        logic                    ok;
        logic signed [TW-1:0]    tin;
        logic signed [TW-1:0]    tout;
        logic signed [NRM_W-1:0] nsel;
    } t_slab;

    function automatic t_slab f_slab(input logic zero, input logic pass,
                                     input logic signed [TW-1:0] t0,
                                     input logic signed [TW-1:0] t1,
                                     input logic signed [TW-1:0] tin,
                                     input logic signed [TW-1:0] tout);
        t_slab                s;
        logic                 lt;
        logic signed [TW-1:0] tmn;
        logic signed [TW-1:0] tmx;
        s.tin  = tin;
        s.tout = tout;
        s.nsel = NRM_ZERO;
        lt     = (t0 < t1);
        tmn    = lt ? t0 : t1;
        tmx    = lt ? t1 : t0;
        if (zero) begin
            s.ok = pass;
        end else begin
            if (tmn > tin) begin
                s.tin  = tmn;
                s.nsel = lt ? NRM_NEG : NRM_POS;
            end
            if (tmx < tout) s.tout = tmx;
            s.ok = (s.tin <= s.tout);
        end
        return s;
    endfunction

    logic                en;
    logic [NQ-1:0]       q   [LANES];
    logic [LANES-1:0]    rnz;
    logic [LANES-1:0]    sat;
    logic [NQ:0]         r_v;
    t_side               r_sb [0:NQ];
    logic                r_av;
    t_side               r_as;
    logic [TW-1:0]       r_t  [LANES];
    logic [TW-1:0]       n_t  [LANES];
    logic [TW-1:0]       qs;
    logic [TW-1:0]       c;
    t_slab               sx;
    t_slab               sy;
    logic                r_ov;
    logic                r_hit;
    logic [FRACTION_BITS:0]  r_time;
    logic signed [NRM_W-1:0] r_nx;
    logic signed [NRM_W-1:0] r_ny;

    assign en    = !r_ov || o_toi.ready;
    assign o_pop = en && i_valid;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        swbx_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_mag    (i_cls.mag[g]),
            .i_den    (i_cls.den[g >> 1]),
            .o_q      (q[g]),
            .o_rem_nz (rnz[g]),
            .o_sat    (sat[g])
        );
    end

    always_comb begin
        qs = '0;
        c  = '0;
        for (int g = 0; g < LANES; g++) begin
            qs = TW'(q[g]);
            c  = qs + TW'(rnz[g]);
            if (r_sb[NQ].neg[g]) begin
                n_t[g] = (sat[g] || c > SAT_U) ? TW'(-SAT_U) : TW'(-c);
            end else begin
                n_t[g] = (sat[g] || qs > SAT_U) ? SAT_U : qs;
            end
        end
    end

    always_comb begin
        sx = f_slab(r_as.zero[AX_X], r_as.pass[AX_X], $signed(r_t[LN_LX]),
                    $signed(r_t[LN_HX]), '0, ONE_T);
        sy = f_slab(r_as.zero[AX_Y], r_as.pass[AX_Y], $signed(r_t[LN_LY]),
                    $signed(r_t[LN_HY]), sx.tin, sx.tout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NQ-1:0], i_valid};
            r_av <= r_v[NQ];
            r_ov <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= i_cls.side;
            for (int k = 1; k <= NQ; k++) r_sb[k] <= r_sb[k-1];
            r_as <= r_sb[NQ];
            for (int g = 0; g < LANES; g++) r_t[g] <= n_t[g];
            if (sx.ok && sy.ok) begin
                r_hit  <= 1'b1;
                r_time <= sy.tin[FRACTION_BITS:0];
                r_nx   <= (sy.nsel != NRM_ZERO) ? NRM_ZERO : sx.nsel;
                r_ny   <= sy.nsel;
            end else begin
                r_hit  <= 1'b0;
                r_time <= '0;
                r_nx   <= NRM_ZERO;
                r_ny   <= NRM_ZERO;
            end
        end
    end

    assign o_toi.valid       = r_ov;
    assign o_toi.hit         = r_hit;
    assign o_toi.impact_time = r_time;
    assign o_toi.normal_x    = r_nx;
    assign o_toi.normal_y    = r_ny;

endmodule

// ----- hdl/swept_box_time_of_impact_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload
// i_box     in   mover/target min, max and end centre, x and y, signed Q16.16
// o_toi     out  hit, impact_time (Q1.FRACTION_BITS, unsigned), normal_x, normal_y
//
// One item per cycle sustained while o_toi.ready holds; the four restoring dividers
// produce one quotient bit per stage.
// Reset (synchronous, active low) clears valid flags and the queue pointers and count only.
// An output stall freezes the back pipeline; the four-entry queue and the front
// register absorb items, then i_box.ready drops.
module swept_box_time_of_impact_unit import swbx_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swbx_box_if.sink    i_box,
    swbx_toi_if.source  o_toi
);

    t_cls front_cls;
    t_cls queue_cls;
    logic front_valid;
    logic queue_ready;
    logic queue_valid;
    logic back_pop;

    swbx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (i_box),
        .o_cls   (front_cls),
        .o_valid (front_valid),
        .i_ready (queue_ready)
    );

    swbx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cls   (front_cls),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .o_cls   (queue_cls),
        .o_valid (queue_valid),
        .i_pop   (back_pop)
    );

    swbx_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cls   (queue_cls),
        .i_valid (queue_valid),
        .o_pop   (back_pop),
        .o_toi   (o_toi)
    );

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_toi.valid && !o_toi.hit |->
            o_toi.impact_time == '0 && o_toi.normal_x == NRM_ZERO &&
            o_toi.normal_y == NRM_ZERO)
        else $error("miss with nonzero time or normal");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_toi.valid && o_toi.hit |->
            o_toi.impact_time <= ((FRACTION_BITS+1)'(1) << FRACTION_BITS))
        else $error("impact time above one");

    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_toi.valid |-> !(o_toi.normal_x != NRM_ZERO && o_toi.normal_y != NRM_ZERO))
        else $error("normal on both axes");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_box.ready |-> $past(o_toi.valid && !o_toi.ready))
        else $error("input stalled without output stall");

endmodule

// ----- bench/swept_box_time_of_impact_unit_tb.sv -----
`timescale 1ns / 1ps
module swept_box_time_of_impact_unit_tb;
    import swbx_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam longint ONE_T = 64'sd1 <<< FB;
    localparam longint SAT_T = 64'sd1 <<< (FB + 1);
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic signed [DATA_W-1:0] mnx, mny, mxx, mxy, aex, aey;
        logic signed [DATA_W-1:0] bnx, bny, bxx, bxy, bex, bey;
    } query_t;

    typedef struct packed {
        logic                    hit;
        logic [FB:0]             t;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
    } contact_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    swbx_box_if box_if ();
    swbx_toi_if #(.FRACTION_BITS(FB)) toi_if ();

    swept_box_time_of_impact_unit #(.FRACTION_BITS(FB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_if.sink),
        .o_toi   (toi_if.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    query_t   pending_q[$];
    contact_t contact_q[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int n_mismatch = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_hits = 0;
    int cycles = 0;
    bit drv_busy = 0;

    function automatic longint floor_time(longint num, longint den);
        longint scaled, q;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        scaled = num * ONE_T;
        q = scaled / den;
        if ((scaled % den) != 0 && scaled < 0) q = q - 1;
        if (q > SAT_T) q = SAT_T;
        if (q < -SAT_T) q = -SAT_T;
        return q;
    endfunction

    function automatic bit cut_slab(longint s, longint v, longint lo, longint hi,
                                    inout longint t_in, inout longint t_out,
                                    inout int n_in);
        longint t0, t1;
        if (v == 0) return (s >= lo) && (s <= hi);
        t0 = floor_time(lo - s, v);
        t1 = floor_time(hi - s, v);
        if ((t0 < t1 ? t0 : t1) > t_in) begin
            t_in = t0 < t1 ? t0 : t1;
            n_in = t0 < t1 ? -1 : 1;
        end
        if ((t0 < t1 ? t1 : t0) < t_out) t_out = t0 < t1 ? t1 : t0;
        return t_in <= t_out;
    endfunction

    function automatic contact_t sweep_contact(query_t q);
        longint pax, pay, pbx, pby, vx, vy, wx, wy, t_in, t_out;
        int nx, ny, nsel;
        bit ok;
        contact_t c;
        pax = longint'(q.mnx) + q.mxx;
        pay = longint'(q.mny) + q.mxy;
        pbx = longint'(q.bnx) + q.bxx;
        pby = longint'(q.bny) + q.bxy;
        vx = (2 * longint'(q.aex) - pax) - (2 * longint'(q.bex) - pbx);
        vy = (2 * longint'(q.aey) - pay) - (2 * longint'(q.bey) - pby);
        wx = longint'(q.mxx) - q.mnx;
        wy = longint'(q.mxy) - q.mny;
        t_in = 0;
        t_out = ONE_T;
        nx = 0;
        ny = 0;
        nsel = 0;
        ok = cut_slab(pax, vx, 2 * longint'(q.bnx) - wx, 2 * longint'(q.bxx) + wx,
                      t_in, t_out, nsel);
        if (ok) begin
            nx = nsel;
            nsel = 0;
            ok = cut_slab(pay, vy, 2 * longint'(q.bny) - wy, 2 * longint'(q.bxy) + wy,
                          t_in, t_out, nsel);
            if (ok && nsel != 0) begin
                nx = 0;
                ny = nsel;
            end
        end
        c = '0;
        if (ok && t_in >= 0 && t_in <= ONE_T) begin
            c.hit = 1'b1;
            c.t = t_in[FB:0];
            c.nx = nx[NRM_W-1:0];
            c.ny = ny[NRM_W-1:0];
        end
        return c;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        logic signed [31:0] cx, cy, hx, hy;
        q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        if ($urandom_range(0, 9) < 2) return q;
        if ($urandom_range(0, 9) < 2) begin
            q = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            return q;
        end
        cx = 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
        cy = 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
        hx = $urandom_range(1, 5) <<< 16;
        hy = $urandom_range(1, 5) <<< 16;
        q.mnx = cx - hx;
        q.mxx = cx + hx;
        q.mny = cy - hy;
        q.mxy = cy + hy;
        q.aex = 32'($signed($urandom_range(0, 5242880)) - 2621440);
        q.aey = 32'($signed($urandom_range(0, 5242880)) - 2621440);
        if ($urandom_range(0, 3) == 0) q.aex = cx;
        if ($urandom_range(0, 3) == 0) q.aey = cy;
        hx = $urandom_range(1, 6) <<< 16;
        hy = $urandom_range(1, 6) <<< 16;
        q.bnx = -hx;
        q.bxx = hx;
        q.bny = -hy;
        q.bxy = hy;
        q.bex = $urandom_range(0, 3) == 0 ? 32'($signed($urandom_range(0, 131072)) - 65536) : 0;
        q.bey = $urandom_range(0, 3) == 0 ? 32'($signed($urandom_range(0, 131072)) - 65536) : 0;
        return q;
    endfunction

    function automatic query_t fill_query(logic signed [31:0] v);
        return {12{v}};
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            box_if.valid <= 1'b0;
            toi_if.ready <= 1'b0;
        end else begin
            toi_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            if (!box_if.valid || drv_busy == 0) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    query_t q;
                    q = pending_q.pop_front();
                    {box_if.mover_min_x, box_if.mover_min_y, box_if.mover_max_x,
                     box_if.mover_max_y, box_if.mover_end_x, box_if.mover_end_y,
                     box_if.target_min_x, box_if.target_min_y, box_if.target_max_x,
                     box_if.target_max_y, box_if.target_end_x, box_if.target_end_y} <= q;
                    box_if.valid <= 1'b1;
                    drv_busy = 1;
                end else begin
                    box_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && box_if.valid && box_if.ready) begin
            contact_q.push_back(sweep_contact({box_if.mover_min_x, box_if.mover_min_y,
                box_if.mover_max_x, box_if.mover_max_y, box_if.mover_end_x,
                box_if.mover_end_y, box_if.target_min_x, box_if.target_min_y,
                box_if.target_max_x, box_if.target_max_y, box_if.target_end_x,
                box_if.target_end_y}));
            n_sent++;
            drv_busy = 0;
        end
        if (i_rst_n && toi_if.valid && toi_if.ready) begin
            contact_t got, want;
            got = {toi_if.hit, toi_if.impact_time, toi_if.normal_x, toi_if.normal_y};
            n_recv++;
            if (got.hit) n_hits++;
            if (contact_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected transfer: %p", got);
            end else begin
                want = contact_q.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected hit=%0b t=%0d n=(%0d,%0d) got hit=%0b t=%0d n=(%0d,%0d)",
                                 want.hit, want.t, want.nx, want.ny,
                                 got.hit, got.t, got.nx, got.ny);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic run_phase(int idle, int stall, int count);
        idle_pct = idle;
        stall_pct = stall;
        for (int k = 0; k < count; k++) pending_q.push_back(rand_query());
        while (pending_q.size() > 0 || drv_busy || contact_q.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        query_t q;
        box_if.valid = 1'b0;
        box_if.mover_min_x = '0; box_if.mover_min_y = '0;
        box_if.mover_max_x = '0; box_if.mover_max_y = '0;
        box_if.mover_end_x = '0; box_if.mover_end_y = '0;
        box_if.target_min_x = '0; box_if.target_min_y = '0;
        box_if.target_max_x = '0; box_if.target_max_y = '0;
        box_if.target_end_x = '0; box_if.target_end_y = '0;
        toi_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending_q.push_back(fill_query(32'sh7fffffff));
        pending_q.push_back(fill_query(32'sh80000000));
        pending_q.push_back(fill_query(32'sh0));
        pending_q.push_back(fill_query(32'shffffffff));
        // start inside
        q = '0; q.mnx = -65536; q.mxx = 65536; q.mny = -65536; q.mxy = 65536;
        q.bnx = -131072; q.bxx = 131072; q.bny = -131072; q.bxy = 131072;
        pending_q.push_back(q);
        // head-on along x from both sides, then along y
        q = '0; q.mnx = -10 <<< 16; q.mxx = -8 <<< 16; q.mny = -65536; q.mxy = 65536;
        q.aex = 10 <<< 16; q.bnx = -65536; q.bxx = 65536; q.bny = -65536; q.bxy = 65536;
        pending_q.push_back(q);
        q.mnx = 8 <<< 16; q.mxx = 10 <<< 16; q.aex = -(10 <<< 16);
        pending_q.push_back(q);
        q = '0; q.mny = -10 <<< 16; q.mxy = -8 <<< 16; q.mnx = -65536; q.mxx = 65536;
        q.aey = 10 <<< 16; q.bnx = -65536; q.bxx = 65536; q.bny = -65536; q.bxy = 65536;
        pending_q.push_back(q);
        // zero motion outside, parallel miss, inverted boxes
        q.aey = -9 <<< 16;
        pending_q.push_back(q);
        q.aex = 20 <<< 16; q.aey = 10 <<< 16; q.mnx = 19 <<< 16; q.mxx = 21 <<< 16;
        pending_q.push_back(q);
        q = '0; q.mnx = 65536; q.mxx = -65536; q.mny = 65536; q.mxy = -65536;
        q.aex = 5 <<< 16; q.bnx = 3 <<< 16; q.bxx = 2 <<< 16; q.bny = 1; q.bxy = -1;
        pending_q.push_back(q);
        // exact contact at the end of the step, diagonal corner
        q = '0; q.mnx = -4 <<< 16; q.mxx = -2 <<< 16; q.mny = -4 <<< 16; q.mxy = -2 <<< 16;
        q.aex = -2 <<< 16; q.aey = -2 <<< 16; q.bnx = -65536; q.bxx = 65536;
        q.bny = -65536; q.bxy = 65536;
        pending_q.push_back(q);
        q.bex = 3; q.bey = -3;
        pending_q.push_back(q);
        run_phase(0, 0, 200);
        run_phase(74, 0, 200);
        run_phase(0, 74, 200);
        run_phase(27, 27, 200);
        repeat (3 * FB + 30) @(posedge i_clk);

        $display("%0d queries sent, %0d results checked, %0d hits, four idle/stall mixes",
                 n_sent, n_recv, n_hits);
        if (n_mismatch == 0 && contact_q.size() == 0 && n_recv == n_sent) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_mismatch, contact_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/swbx_pkg.sv
hdl/swbx_intf.sv
hdl/swbx_front.sv
hdl/swbx_fifo.sv
hdl/swbx_div.sv
hdl/swbx_back.sv
hdl/swept_box_time_of_impact_unit.sv
bench/swept_box_time_of_impact_unit_tb.sv
